FILE: src/ant_pkg.sv
// shared types and constants for the active node table
package ant_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CNT_OUT_W = 8;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;
    localparam logic [CNT_OUT_W-1:0] COUNT_MAX  = 8'd255;

    // configuration register word index
    localparam logic REG_TIMEOUT = 1'b0;

    // command codes
    localparam logic CMD_HEARD = 1'b0;
    localparam logic CMD_COUNT = 1'b1;

    // status codes
    localparam logic [1:0] ST_REFRESHED = 2'd0;
    localparam logic [1:0] ST_ADDED     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_COUNT     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] last_seen;
    } entry_t;

endpackage

FILE: src/active_node_table_with_aging.sv
// top level of the active node table with timeout aging
//
// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     command, node_id, now_ms
// out       source     out_valid / out_ready   status, active_count
// cfg       apb slave  psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// from accept to result the sequencer walks every entry held, then writes the
// result in the finish state; with the output register free it returns to idle,
// where the next accept can follow; each entry is read in a read state and judged
// in an evaluate state through the single read port of the entry memory and one
// shared age subtract-and-compare unit
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next transaction may be accepted meanwhile
// reset clears the sequencer, the entry count and the timeout (30000); the
// entry memory itself is not cleared, entries beyond the count are never read
module active_node_table_with_aging #(
    parameter int unsigned MAX_NODES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [15:0] node_id,
    input  logic [31:0] now_ms,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  active_count,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ant_pkg::*;

    localparam int unsigned IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] timeout_reg;

    // transaction context
    logic              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;

    // walk control
    logic [CNT_W-1:0] count_reg, count_next;   // entries held
    logic [CNT_W-1:0] idx_reg, idx_next;       // entry being read
    logic [CNT_W-1:0] kept_reg, kept_next;     // survivors so far
    logic             found_reg, found_next;
    logic [IDX_W-1:0] match_reg, match_next;   // compacted slot of the match

    // output register
    logic                 out_valid_reg;
    logic [1:0]           status_reg, status_next;
    logic [CNT_OUT_W-1:0] acnt_reg, acnt_next;

    // memory ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    entry_t           rd_data;

    logic in_fire;
    logic out_free;
    logic alive;
    logic [TIME_W-1:0] age;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  final_cnt;
    logic [31:0]       final_wide;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // shared age unit: wrap-around subtract then compare against the timeout
    assign age   = now_reg - rd_data.last_seen;
    assign alive = (age < timeout_reg);

    assign idx_inc = idx_reg + CNT_W'(1);

    // memory instance
    ant_store #(
        .DEPTH (MAX_NODES),
        .AW    (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign rd_en = (state_reg == S_READ);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        kept_next   = kept_reg;
        found_next  = found_reg;
        match_next  = match_reg;
        status_next = status_reg;
        final_cnt   = count_reg;
        wr_en       = 1'b0;
        wr_addr     = kept_reg[IDX_W-1:0];
        wr_data     = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next   = '0;
                    kept_next  = '0;
                    found_next = 1'b0;
                    state_next = (count_reg == '0) ? S_FIN : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (alive)
                begin
                    kept_next = kept_reg + CNT_W'(1);
                    // compaction only on a heard transaction
                    if (cmd_reg == CMD_HEARD)
                    begin
                        wr_en = 1'b1;
                        if (!found_reg && rd_data.id == id_reg)
                        begin
                            found_next = 1'b1;
                            match_next = kept_reg[IDX_W-1:0];
                        end
                    end
                end
                idx_next   = idx_inc;
                state_next = (idx_inc == count_reg) ? S_FIN : S_READ;
            end
            S_FIN:
            begin
                wr_data.id        = id_reg;
                wr_data.last_seen = now_reg;
                if (cmd_reg == CMD_COUNT)
                begin
                    status_next = ST_COUNT;
                    final_cnt   = kept_reg;
                end
                else if (found_reg)
                begin
                    // refresh the surviving entry in place
                    wr_addr     = match_reg;
                    wr_en       = out_free;
                    status_next = ST_REFRESHED;
                    final_cnt   = kept_reg;
                    count_next  = out_free ? kept_reg : count_reg;
                end
                else if (kept_reg < MAX_CNT)
                begin
                    // append after the survivors
                    wr_en       = out_free;
                    status_next = ST_ADDED;
                    final_cnt   = kept_reg + CNT_W'(1);
                    count_next  = out_free ? final_cnt : count_reg;
                end
                else
                begin
                    status_next = ST_FULL;
                    final_cnt   = kept_reg;
                    count_next  = out_free ? kept_reg : count_reg;
                end
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // saturate the reported count to the output width
    assign final_wide = 32'(final_cnt);
    assign acnt_next  = (final_wide > 32'(COUNT_MAX)) ? COUNT_MAX
                                                      : final_wide[CNT_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            kept_reg  <= kept_next;
            found_reg <= found_next;
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
            begin
                timeout_reg <= pwdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        if (in_fire)
        begin
            cmd_reg <= command;
            id_reg  <= node_id;
            now_reg <= now_ms;
        end
        if (state_reg == S_FIN && out_free)
        begin
            status_reg <= status_next;
            acnt_reg   <= acnt_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign active_count = acnt_reg;

    // apb read side
    assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_reg : 32'd0;
    assign pready = 1'b1;

endmodule

FILE: src/ant_store.sv
// single-port-write, single-port-read entry memory with registered read data
module ant_store #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ant_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output ant_pkg::entry_t rd_data
);
    import ant_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ant_checker.sv
// port-level checks for the active node table, bound to the top level
module ant_checker #(
    parameter int unsigned MAX_NODES = 128
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  active_count,
    input logic        pready
);
    import ant_pkg::*;

    localparam logic [7:0] FULL_CNT = (MAX_NODES > 255) ? 8'd255 : 8'(MAX_NODES);

    // a pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(active_count))
    else $error("result changed while stalled");

    // the sequencer is busy right after taking a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

    // a heard transaction always leaves at least one entry unless dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_REFRESHED || status == ST_ADDED) |-> active_count != 8'd0)
    else $error("empty table after refresh or add");

    // a drop happens only with a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> active_count == FULL_CNT)
    else $error("drop reported with room left");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind active_node_table_with_aging ant_checker #(.MAX_NODES(MAX_NODES)) u_ant_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .active_count (active_count),
    .pready       (pready)
);

FILE: tb/node_table_checker.sv
// watches the channels of the active node table, predicts each reply and compares
module node_table_checker
    import ant_pkg::*;
#(
    parameter int unsigned MAX_NODES = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 command,
    input  logic [ID_W-1:0]      node_id,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           status,
    input  logic [CNT_OUT_W-1:0] active_count,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic [31:0]          prdata,
    input  logic                 pready,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
    // keep the log readable when the block is badly broken
    localparam int MAX_SHOWN = 200;

    typedef struct packed {
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] count;
    } reply_t;

    logic [ID_W-1:0]   id_tbl   [MAX_NODES];
    logic [TIME_W-1:0] seen_tbl [MAX_NODES];
    int                held;
    logic [TIME_W-1:0] timeout;
    reply_t            replies_due [$];
    int                shown;

    function automatic logic [CNT_OUT_W-1:0] clip_count(input int n);
        return (n > COUNT_MAX) ? COUNT_MAX : CNT_OUT_W'(n);
    endfunction

    // prune expired entries, then refresh, append or drop; a query only counts
    function automatic reply_t apply_event(input logic cmd, input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] t);
        int                kept;
        int                k;
        logic [TIME_W-1:0] age;
        reply_t            r;
        kept = 0;
        if (cmd == CMD_COUNT) begin
            for (k = 0; k < held; k++) begin
                age = t - seen_tbl[k];
                if (age < timeout)
                    kept++;
            end
            r.status = ST_COUNT;
            r.count  = clip_count(kept);
            return r;
        end
        for (k = 0; k < held; k++) begin
            age = t - seen_tbl[k];
            if (age < timeout) begin
                id_tbl[kept]   = id_tbl[k];
                seen_tbl[kept] = seen_tbl[k];
                kept++;
            end
        end
        held = kept;
        r.status = ST_FULL;
        // ids in the table are unique, so at most one entry matches
        for (k = 0; k < held; k++) begin
            if (id_tbl[k] == id) begin
                seen_tbl[k] = t;
                r.status    = ST_REFRESHED;
            end
        end
        if (r.status != ST_REFRESHED && held < MAX_NODES) begin
            id_tbl[held]   = id;
            seen_tbl[held] = t;
            held++;
            r.status = ST_ADDED;
        end
        r.count = clip_count(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        reply_t want;
        if (!rst_n) begin
            held    = 0;
            timeout = TIMEOUT_RESET;
            replies_due.delete();
            pending = 0;
            errors  = 0;
            shown   = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (replies_due.size() == 0) begin
                    errors++;
                    if (shown++ < MAX_SHOWN)
                        $display("%0t: unexpected reply: expected none, got status %0d count %0d",
                                 $time, status, active_count);
                end else begin
                    want = replies_due.pop_front();
                    if (status !== want.status) begin
                        errors++;
                        if (shown++ < MAX_SHOWN)
                            $display("%0t: status mismatch: expected %0d, got %0d",
                                     $time, want.status, status);
                    end
                    if (active_count !== want.count) begin
                        errors++;
                        if (shown++ < MAX_SHOWN)
                            $display("%0t: active_count mismatch: expected %0d, got %0d",
                                     $time, want.count, active_count);
                    end
                end
            end
            if (in_valid && in_ready)
                replies_due.push_back(apply_event(command, node_id, now_ms));
            if (psel && penable && pready && paddr == ADDR_TIMEOUT) begin
                if (pwrite) begin
                    timeout = pwdata;
                end else if (prdata !== timeout) begin
                    errors++;
                    if (shown++ < MAX_SHOWN)
                        $display("%0t: timeout readback mismatch: expected %0d, got %0d",
                                 $time, timeout, prdata);
                end
            end
            pending = replies_due.size();
        end
    end

endmodule

FILE: tb/tb_active_node_table_with_aging.sv
// stimulus, clock, reset and verdict for the active node table
module tb_active_node_table_with_aging;
    import ant_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_NODES = 128;
    localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
    // the first index past the register list, writes there must be ignored
    localparam logic [2:0] ADDR_SPARE = {~REG_TIMEOUT, 2'b00};
    // the limit is many times over the worst single transaction with a full
    // table and over the long receiver hold-off below
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    // settle time at the end, a bit more than the full-table latency
    localparam int TAIL_CYCLES = 300;
    localparam logic WR = 1'b1;
    localparam logic RD = 1'b0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [15:0] node_id;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  active_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_len = 0;
    int          quiet_cycles = 0;
    logic [31:0] cur_time;

    active_node_table_with_aging #(
        .MAX_NODES(MAX_NODES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .node_id     (node_id),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .active_count(active_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    node_table_checker #(
        .MAX_NODES(MAX_NODES)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .node_id     (node_id),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .active_count(active_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .pending     (pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog: ends the run once no transaction has moved for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                // hold off while the sender keeps offering, so the block fills and stalls
                out_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offer one transaction, with random gaps before it, and wait for acceptance
    task automatic send_event(input logic cmd, input logic [15:0] id, input logic [31:0] t);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        node_id  <= id;
        now_ms   <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering and wait for every outstanding reply, leaving the block idle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    // one apb transfer: setup cycle, then access cycle (pready is always high)
    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // change the timeout between phases and read it back
    task automatic set_timeout(input logic [31:0] value);
        drain();
        reg_access(WR, ADDR_TIMEOUT, value);
        reg_access(RD, ADDR_TIMEOUT, '0);
    endtask

    // random traffic: heard events from a small id pool so entries get refreshed,
    // queries with random ids, time moving forward with occasional far jumps
    task automatic run_phase(input int items, input int pool_n, input int max_step,
                             input int query_pct, input int jump_pct, input int hold_at);
        logic [15:0] pool [256];
        logic        cmd;
        logic [15:0] id;
        int          k;
        for (k = 0; k < pool_n; k++)
            pool[k] = 16'($urandom);
        for (k = 0; k < items; k++)
        begin
            if (k == hold_at)
                hold_len = HOLD_CYCLES;
            // a far jump may land in the past, so entries look like they are in the future
            if ($urandom_range(99) < jump_pct)
                cur_time = $urandom;
            else
                cur_time += $urandom_range(max_step);
            cmd = ($urandom_range(99) < query_pct) ? CMD_COUNT : CMD_HEARD;
            id  = (cmd == CMD_COUNT) ? 16'($urandom) : pool[$urandom_range(pool_n - 1)];
            send_event(cmd, id, cur_time);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        command  = CMD_HEARD;
        node_id  = '0;
        now_ms   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_time = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver often stalls
        tx_idle_pct = 9;
        rx_idle_pct = 46;

        // directed part at the reset timeout of 30000
        reg_access(RD, ADDR_TIMEOUT, '0);
        send_event(CMD_COUNT, 16'hFFFF, 32'd0);          // query on an empty table
        send_event(CMD_HEARD, 16'h0000, 32'd0);          // first add
        send_event(CMD_HEARD, 16'hFFFF, 32'hFFFF_FFFF);  // previous entry ages out at max age
        send_event(CMD_HEARD, 16'hFFFF, 32'd100);        // time wraps, entry still fresh
        send_event(CMD_HEARD, 16'h5555, 32'd29000);
        send_event(CMD_HEARD, 16'hAAAA, 32'd30100);      // oldest entry exactly at timeout
        send_event(CMD_COUNT, 16'h0000, 32'd59000);      // one at timeout, one just below
        send_event(CMD_COUNT, 16'h1234, 32'd20000);      // entries seem to lie in the future
        send_event(CMD_COUNT, 16'h0000, 32'hFFFF_FFFF);

        // zero timeout: every entry counts as expired
        set_timeout(32'd0);
        send_event(CMD_HEARD, 16'h1234, 32'd5);
        send_event(CMD_HEARD, 16'h1234, 32'd5);
        send_event(CMD_COUNT, 16'h1234, 32'd5);

        // smallest nonzero timeout: only an age of zero survives
        set_timeout(32'd1);
        send_event(CMD_HEARD, 16'h0007, 32'd1000);
        send_event(CMD_HEARD, 16'h0007, 32'd1000);
        send_event(CMD_HEARD, 16'h0008, 32'd1000);
        send_event(CMD_COUNT, 16'h0008, 32'd1001);

        // largest timeout, and a write past the register list that must not land
        set_timeout(32'hFFFF_FFFF);
        reg_access(WR, ADDR_SPARE, 32'd5);
        reg_access(RD, ADDR_TIMEOUT, '0);
        send_event(CMD_HEARD, 16'h0009, 32'd1000);
        send_event(CMD_HEARD, 16'h0007, 32'd999);        // one step back is the maximum age
        send_event(CMD_COUNT, 16'hFFFF, 32'h7FFF_FFFF);

        // fill the table past capacity, with the long receiver hold-off midway
        set_timeout(32'hFFFF_FFFF);
        run_phase(350, 170, 3, 10, 0, 150);

        // steady churn around a moderate timeout
        set_timeout(32'd3000);
        run_phase(280, 100, 80, 20, 2, -1);

        // sender now often idle, receiver mostly ready
        tx_idle_pct = 46;
        rx_idle_pct = 9;
        set_timeout(32'd1);
        run_phase(150, 6, 1, 25, 0, -1);

        // time runs through the 32-bit wrap
        set_timeout($urandom_range(5000, 100));
        cur_time = 32'hFFFF_F000;
        run_phase(200, 40, 50, 15, 0, -1);

        // no idling on either side from here on
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_timeout($urandom);
        run_phase(150, 30, 1000, 20, 30, -1);

        set_timeout(32'd0);
        run_phase(50, 10, 5, 30, 0, -1);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: active_node_table_with_aging.f
src/ant_pkg.sv
src/ant_store.sv
src/active_node_table_with_aging.sv
src/ant_checker.sv
tb/node_table_checker.sv
tb/tb_active_node_table_with_aging.sv
